// ===== src/udpc_pkg.sv =====
// shared types, codes and constants of the reliable-udp connection state machine
// no dependencies; used by every module of the block
package udpc_pkg;

   localparam int TimerWidthDefault = 16;
   localparam int NumRegs           = 7;
   localparam int CsrIndexW         = $clog2(NumRegs + 1);
   localparam int CsrDataW          = 16;
   localparam int TagW              = 32;
   localparam int MaxRun            = 4;
   localparam int RunCntW           = $clog2(MaxRun + 1);
   localparam int RunIdxW           = $clog2(MaxRun);
   localparam int RunQueueDepth     = 2;

   // register index, also the index of the timer it governs
   localparam int RegHpn    = 0;
   localparam int RegSyn    = 1;
   localparam int RegAck    = 2;
   localparam int RegOpen   = 3;
   localparam int RegKeep   = 4;
   localparam int RegInact  = 5;
   localparam int RegCwait  = 6;

   localparam logic [CsrDataW-1:0] RegReset [NumRegs] = '{
      16'd100, 16'd100, 16'd100, 16'd5000, 16'd1000, 16'd10000, 16'd2000
   };

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_OPEN  = 2'd1,
      OP_CLOSE = 2'd2,
      OP_RECV  = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_INIT   = 3'd0,
      ST_SYNS   = 3'd1,
      ST_SYNR   = 3'd2,
      ST_OPEN   = 3'd3,
      ST_CWAIT  = 3'd4,
      ST_CLOSED = 3'd5
   } link_state_type;

   typedef enum logic [3:0] {
      A_NONE   = 4'd0,
      A_HPN    = 4'd1,
      A_SYN    = 4'd2,
      A_ACK    = 4'd3,
      A_NUL    = 4'd4,
      A_RST    = 4'd5,
      A_OPENED = 4'd6,
      A_TMO    = 4'd7,
      A_CLOSED = 4'd8,
      A_RRUN   = 4'd9,
      A_RACK   = 4'd10,
      A_REAK   = 4'd11,
      A_RDATA  = 4'd12,
      A_UDATA  = 4'd13
   } action_type;

   // one classified event: its action list and the link after it
   typedef struct packed {
      action_type [MaxRun-1:0] acts;
      logic [RunCntW-1:0]      cnt;
      logic [TagW-1:0]         own_tag;
      logic [TagW-1:0]         peer_tag;
      link_state_type          state;
   } run_type;

   // handshake between the front and the run queue
   typedef struct packed {
      logic    push;
      run_type run;
   } run_push_type;

endpackage

// ===== src/udp_connection_handshake_fsm.sv =====
// top level of the reliable-udp connection state machine
// depends on udpc_pkg, udpc_front, udpc_queue and udpc_back
//
// connection state machine for one reliable-udp link. each transaction on the
// req_ side is one event (tick, open, close or a received header) and is taken
// whenever the run queue has room: the front end updates the link state, the
// seven saturating tick timers and the tags right away, and stores the event's
// list of one to four actions. the back end then delivers those actions on the
// rsp_ side, one transaction per clock while the receiver keeps popping, the
// final one with rsp_last set. the result register and a two-entry run queue
// part the sides, so new events keep arriving while results wait. the user
// must write the seven csr_ registers only while the block is idle; the block
// itself does not enforce it. indexes past the list are ignored. timers are
// TIMER_WIDTH bits and saturate at all ones.
module udp_connection_handshake_fsm #(
   parameter int TIMER_WIDTH = udpc_pkg::TimerWidthDefault
) (
   input  logic                           clock,
   input  logic                           reset,

   // configuration writes
   input  logic                           csr_we,
   input  logic [udpc_pkg::CsrIndexW-1:0] csr_index,
   input  logic [udpc_pkg::CsrDataW-1:0]  csr_wdata,

   // event side
   input  logic                           push,
   output logic                           full,
   input  logic [1:0]                     req_opcode,
   input  logic [udpc_pkg::TagW-1:0]      req_self_tag,
   input  logic [udpc_pkg::TagW-1:0]      req_remote_tag,
   input  logic                           req_flag_syn,
   input  logic                           req_flag_rst,
   input  logic                           req_flag_nul,
   input  logic                           req_flag_ack,
   input  logic                           req_flag_eak,
   input  logic                           req_flag_rle,
   input  logic                           req_ack_nonzero,
   input  logic                           req_body_nonzero,

   // action side
   output logic                           empty,
   input  logic                           pop,
   output logic [3:0]                     rsp_action,
   output logic [udpc_pkg::TagW-1:0]      rsp_tx_src_tag,
   output logic [udpc_pkg::TagW-1:0]      rsp_tx_dst_tag,
   output logic [udpc_pkg::TagW-1:0]      rsp_tx_seq,
   output logic                           rsp_needs_cum_ack,
   output logic [2:0]                     rsp_conn_state,
   output logic                           rsp_last
);

   udpc_pkg::run_push_type q_wr;
   udpc_pkg::run_type      q_head;
   logic                   q_full;
   logic                   q_valid;
   logic                   q_pop;

   // the front stalls only on a full run queue
   assign full = q_full;

   // classify each event and keep the link state
   udpc_front #(
      .TIMER_WIDTH(TIMER_WIDTH)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_push         (push),
      .req_opcode       (req_opcode),
      .req_self_tag     (req_self_tag),
      .req_remote_tag   (req_remote_tag),
      .req_flag_syn     (req_flag_syn),
      .req_flag_rst     (req_flag_rst),
      .req_flag_nul     (req_flag_nul),
      .req_flag_ack     (req_flag_ack),
      .req_flag_eak     (req_flag_eak),
      .req_flag_rle     (req_flag_rle),
      .req_ack_nonzero  (req_ack_nonzero),
      .req_body_nonzero (req_body_nonzero),
      .q_full           (q_full),
      .q_wr             (q_wr)
   );

   // runs waiting for the back end
   udpc_queue #(
      .DEPTH(udpc_pkg::RunQueueDepth)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .wr    (q_wr),
      .full  (q_full),
      .pop   (q_pop),
      .valid (q_valid),
      .head  (q_head)
   );

   // serialize each run into result transactions
   udpc_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_head            (q_head),
      .q_pop             (q_pop),
      .rsp_empty         (empty),
      .rsp_pop           (pop),
      .rsp_action        (rsp_action),
      .rsp_tx_src_tag    (rsp_tx_src_tag),
      .rsp_tx_dst_tag    (rsp_tx_dst_tag),
      .rsp_tx_seq        (rsp_tx_seq),
      .rsp_needs_cum_ack (rsp_needs_cum_ack),
      .rsp_conn_state    (rsp_conn_state),
      .rsp_last          (rsp_last)
   );

endmodule

// ===== src/udpc_queue.sv =====
// short queue of classified runs between the front and the back
// depends on udpc_pkg for run_type
module udpc_queue #(
   parameter int DEPTH = udpc_pkg::RunQueueDepth
) (
   input  logic                  clock,
   input  logic                  reset,
   input  udpc_pkg::run_push_type wr,
   output logic                  full,
   input  logic                  pop,
   output logic                  valid,
   output udpc_pkg::run_type     head
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   udpc_pkg::run_type slot_ff [DEPTH];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   cnt_ff, cnt_in;
   logic              do_wr, do_rd;

   assign full  = (cnt_ff == CntW'(DEPTH));
   assign valid = (cnt_ff != '0);
   assign head  = slot_ff[rd_ptr_ff];
   assign do_wr = wr.push && !full;
   assign do_rd = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
         cnt_in = cnt_ff + CntW'(1);
      end else if (do_rd && !do_wr) begin
         cnt_in = cnt_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr.run;
      end
   end

endmodule

// ===== src/udpc_front.sv =====
// front end: config registers, link state, timers and event classification
// depends on udpc_pkg; feeds one run per accepted transaction into udpc_queue
module udpc_front #(
   parameter int TIMER_WIDTH = udpc_pkg::TimerWidthDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [udpc_pkg::CsrIndexW-1:0] csr_index,
   input  logic [udpc_pkg::CsrDataW-1:0]  csr_wdata,
   input  logic                           req_push,
   input  logic [1:0]                     req_opcode,
   input  logic [udpc_pkg::TagW-1:0]      req_self_tag,
   input  logic [udpc_pkg::TagW-1:0]      req_remote_tag,
   input  logic                           req_flag_syn,
   input  logic                           req_flag_rst,
   input  logic                           req_flag_nul,
   input  logic                           req_flag_ack,
   input  logic                           req_flag_eak,
   input  logic                           req_flag_rle,
   input  logic                           req_ack_nonzero,
   input  logic                           req_body_nonzero,
   input  logic                           q_full,
   output udpc_pkg::run_push_type         q_wr
);

   localparam int NR   = udpc_pkg::NumRegs;
   localparam int CmpW = (TIMER_WIDTH > udpc_pkg::CsrDataW) ? TIMER_WIDTH : udpc_pkg::CsrDataW;
   localparam logic [TIMER_WIDTH-1:0] TimerMax = {TIMER_WIDTH{1'b1}};

   logic [udpc_pkg::CsrDataW-1:0] cfg_ff [NR];
   logic [TIMER_WIDTH-1:0]        tmr_ff [NR];
   logic [TIMER_WIDTH-1:0]        tmr_in [NR];
   logic [TIMER_WIDTH-1:0]        bump   [NR];
   logic [NR-1:0]                 fire;

   udpc_pkg::link_state_type      state_ff, state_in, state_mid;
   logic [udpc_pkg::TagW-1:0]     own_ff, own_in, peer_ff, peer_in;

   udpc_pkg::opcode_type          op;
   logic                          accept;
   logic                          hs;
   logic                          ack_opens;
   udpc_pkg::action_type [udpc_pkg::MaxRun-1:0] acts;
   logic [udpc_pkg::RunCntW-1:0]  n;

   assign op     = udpc_pkg::opcode_type'(req_opcode);
   assign accept = req_push && !q_full;
   assign hs     = (state_ff == udpc_pkg::ST_SYNS) || (state_ff == udpc_pkg::ST_SYNR);

   // a non-reliable ack header opens the link from the initial or a handshake state
   assign ack_opens = req_flag_ack
                      && !((state_ff == udpc_pkg::ST_OPEN) && req_ack_nonzero)
                      && (hs || (state_ff == udpc_pkg::ST_INIT));

   // link state seen by the data checks of a received header
   assign state_mid = ack_opens ? udpc_pkg::ST_OPEN : state_ff;

   // saturating bump and compare, one per timer
   always_comb begin
      for (int i = 0; i < NR; i++) begin
         bump[i] = (tmr_ff[i] == TimerMax) ? tmr_ff[i] : tmr_ff[i] + TIMER_WIDTH'(1);
         fire[i] = CmpW'(bump[i]) > CmpW'(cfg_ff[i]);
      end
   end

   // next link state
   always_comb begin
      state_in = state_ff;
      case (op)
         udpc_pkg::OP_TICK: begin
            if (state_ff == udpc_pkg::ST_OPEN && fire[udpc_pkg::RegInact]) begin
               state_in = udpc_pkg::ST_CWAIT;
            end else if (state_ff == udpc_pkg::ST_CWAIT && fire[udpc_pkg::RegCwait]) begin
               state_in = udpc_pkg::ST_CLOSED;
            end
         end
         udpc_pkg::OP_OPEN: begin
            if (state_ff == udpc_pkg::ST_INIT) begin
               state_in = udpc_pkg::ST_SYNS;
            end
         end
         udpc_pkg::OP_CLOSE: begin
            state_in = udpc_pkg::ST_CWAIT;
         end
         udpc_pkg::OP_RECV: begin
            if (req_flag_syn) begin
               if (state_ff == udpc_pkg::ST_CLOSED || state_ff == udpc_pkg::ST_SYNS) begin
                  state_in = udpc_pkg::ST_SYNR;
               end
            end else if (req_flag_rst) begin
               state_in = udpc_pkg::ST_CWAIT;
            end else begin
               state_in = state_mid;
            end
         end
         default: state_in = state_ff;
      endcase
   end

   // timers and tags
   always_comb begin
      for (int i = 0; i < NR; i++) begin
         tmr_in[i] = tmr_ff[i];
      end
      own_in  = own_ff;
      peer_in = peer_ff;
      case (op)
         udpc_pkg::OP_TICK: begin
            for (int i = 0; i < NR; i++) begin
               tmr_in[i] = bump[i];
            end
            if (hs) begin
               if (fire[udpc_pkg::RegHpn])  tmr_in[udpc_pkg::RegHpn]  = '0;
               if (fire[udpc_pkg::RegSyn])  tmr_in[udpc_pkg::RegSyn]  = '0;
               if (state_ff == udpc_pkg::ST_SYNR && fire[udpc_pkg::RegAck]) begin
                  tmr_in[udpc_pkg::RegAck] = '0;
               end
               if (fire[udpc_pkg::RegOpen]) tmr_in[udpc_pkg::RegOpen] = '0;
            end else if (state_ff == udpc_pkg::ST_OPEN) begin
               if (fire[udpc_pkg::RegKeep])  tmr_in[udpc_pkg::RegKeep]  = '0;
               if (fire[udpc_pkg::RegInact]) tmr_in[udpc_pkg::RegCwait] = '0;
            end else if (state_ff == udpc_pkg::ST_CWAIT && fire[udpc_pkg::RegCwait]) begin
               tmr_in[udpc_pkg::RegCwait] = '0;
            end
         end
         udpc_pkg::OP_OPEN: begin
            if (state_ff == udpc_pkg::ST_INIT) begin
               own_in  = req_self_tag;
               peer_in = req_remote_tag;
               tmr_in[udpc_pkg::RegHpn]  = '0;
               tmr_in[udpc_pkg::RegSyn]  = '0;
               tmr_in[udpc_pkg::RegOpen] = '0;
            end
         end
         udpc_pkg::OP_CLOSE: begin
            own_in = own_ff;
         end
         udpc_pkg::OP_RECV: begin
            tmr_in[udpc_pkg::RegKeep]  = '0;
            tmr_in[udpc_pkg::RegInact] = '0;
            if (req_flag_syn) begin
               own_in = req_self_tag;
            end else if (req_flag_rst && state_ff != udpc_pkg::ST_CWAIT) begin
               tmr_in[udpc_pkg::RegCwait] = '0;
            end
         end
         default: own_in = own_ff;
      endcase
   end

   // action list of the event, in emission order
   always_comb begin
      acts = '{default: udpc_pkg::A_NONE};
      n    = '0;
      case (op)
         udpc_pkg::OP_TICK: begin
            if (hs) begin
               if (fire[udpc_pkg::RegHpn]) begin
                  acts[n[udpc_pkg::RunIdxW-1:0]] = udpc_pkg::A_HPN;
                  n = n + udpc_pkg::RunCntW'(1);
               end
               if (fire[udpc_pkg::RegSyn]) begin
                  acts[n[udpc_pkg::RunIdxW-1:0]] = udpc_pkg::A_SYN;
                  n = n + udpc_pkg::RunCntW'(1);
               end
               if (state_ff == udpc_pkg::ST_SYNR && fire[udpc_pkg::RegAck]) begin
                  acts[n[udpc_pkg::RunIdxW-1:0]] = udpc_pkg::A_ACK;
                  n = n + udpc_pkg::RunCntW'(1);
               end
               if (fire[udpc_pkg::RegOpen]) begin
                  acts[n[udpc_pkg::RunIdxW-1:0]] = udpc_pkg::A_TMO;
                  n = n + udpc_pkg::RunCntW'(1);
               end
            end else if (state_ff == udpc_pkg::ST_OPEN) begin
               acts[n[udpc_pkg::RunIdxW-1:0]] = udpc_pkg::A_RRUN;
               n = n + udpc_pkg::RunCntW'(1);
               if (fire[udpc_pkg::RegKeep]) begin
                  acts[n[udpc_pkg::RunIdxW-1:0]] = udpc_pkg::A_NUL;
                  n = n + udpc_pkg::RunCntW'(1);
               end
               if (fire[udpc_pkg::RegInact]) begin
                  acts[n[udpc_pkg::RunIdxW-1:0]] = udpc_pkg::A_RST;
                  n = n + udpc_pkg::RunCntW'(1);
               end
            end else if (state_ff == udpc_pkg::ST_CWAIT && fire[udpc_pkg::RegCwait]) begin
               acts[n[udpc_pkg::RunIdxW-1:0]] = udpc_pkg::A_CLOSED;
               n = n + udpc_pkg::RunCntW'(1);
            end
         end
         udpc_pkg::OP_OPEN: begin
            if (state_ff == udpc_pkg::ST_INIT) begin
               acts[n[udpc_pkg::RunIdxW-1:0]] = udpc_pkg::A_SYN;
               n = n + udpc_pkg::RunCntW'(1);
            end
         end
         udpc_pkg::OP_CLOSE: begin
            acts[n[udpc_pkg::RunIdxW-1:0]] = udpc_pkg::A_RST;
            n = n + udpc_pkg::RunCntW'(1);
         end
         udpc_pkg::OP_RECV: begin
            if (req_flag_syn) begin
               if (state_ff == udpc_pkg::ST_CLOSED || state_ff == udpc_pkg::ST_SYNR) begin
                  acts[n[udpc_pkg::RunIdxW-1:0]] = udpc_pkg::A_SYN;
                  n = n + udpc_pkg::RunCntW'(1);
               end
               if (state_ff == udpc_pkg::ST_SYNR) begin
                  acts[n[udpc_pkg::RunIdxW-1:0]] = udpc_pkg::A_ACK;
                  n = n + udpc_pkg::RunCntW'(1);
               end
            end else if (!req_flag_rst) begin
               if (req_flag_nul) begin
                  acts[n[udpc_pkg::RunIdxW-1:0]] = udpc_pkg::A_ACK;
                  n = n + udpc_pkg::RunCntW'(1);
               end
               if (req_flag_ack && state_ff == udpc_pkg::ST_OPEN && req_ack_nonzero) begin
                  acts[n[udpc_pkg::RunIdxW-1:0]] = udpc_pkg::A_RACK;
                  n = n + udpc_pkg::RunCntW'(1);
               end else if (ack_opens) begin
                  acts[n[udpc_pkg::RunIdxW-1:0]] = udpc_pkg::A_ACK;
                  n = n + udpc_pkg::RunCntW'(1);
                  acts[n[udpc_pkg::RunIdxW-1:0]] = udpc_pkg::A_OPENED;
                  n = n + udpc_pkg::RunCntW'(1);
               end
               if (state_mid == udpc_pkg::ST_OPEN) begin
                  if (req_flag_eak) begin
                     acts[n[udpc_pkg::RunIdxW-1:0]] = udpc_pkg::A_REAK;
                     n = n + udpc_pkg::RunCntW'(1);
                  end else if (req_body_nonzero) begin
                     acts[n[udpc_pkg::RunIdxW-1:0]] =
                        req_flag_rle ? udpc_pkg::A_RDATA : udpc_pkg::A_UDATA;
                     n = n + udpc_pkg::RunCntW'(1);
                  end
               end
            end
         end
         default: n = '0;
      endcase
      // an event with nothing to do still yields one result
      if (n == '0) begin
         acts[0] = udpc_pkg::A_NONE;
         n = udpc_pkg::RunCntW'(1);
      end
   end

   assign q_wr.push         = accept;
   assign q_wr.run.acts     = acts;
   assign q_wr.run.cnt      = n;
   assign q_wr.run.own_tag  = own_in;
   assign q_wr.run.peer_tag = peer_in;
   assign q_wr.run.state    = state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= udpc_pkg::ST_INIT;
         own_ff   <= '0;
         peer_ff  <= '0;
         for (int i = 0; i < NR; i++) begin
            tmr_ff[i] <= '0;
         end
      end else if (accept) begin
         state_ff <= state_in;
         own_ff   <= own_in;
         peer_ff  <= peer_in;
         for (int i = 0; i < NR; i++) begin
            tmr_ff[i] <= tmr_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NR; i++) begin
            cfg_ff[i] <= udpc_pkg::RegReset[i];
         end
      end else if (csr_we && csr_index < udpc_pkg::CsrIndexW'(NR)) begin
         cfg_ff[csr_index] <= csr_wdata;
      end
   end

endmodule

// ===== src/udpc_back.sv =====
// back end: walks each queued run one action per cycle into the result register,
// while the receiver keeps popping; depends on udpc_pkg; reads runs from udpc_queue
module udpc_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_valid,
   input  udpc_pkg::run_type          q_head,
   output logic                       q_pop,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic [3:0]                 rsp_action,
   output logic [udpc_pkg::TagW-1:0]  rsp_tx_src_tag,
   output logic [udpc_pkg::TagW-1:0]  rsp_tx_dst_tag,
   output logic [udpc_pkg::TagW-1:0]  rsp_tx_seq,
   output logic                       rsp_needs_cum_ack,
   output logic [2:0]                 rsp_conn_state,
   output logic                       rsp_last
);

   logic [udpc_pkg::RunIdxW-1:0] idx_ff, idx_in;
   logic                         valid_ff, valid_in;
   logic                         load;
   logic                         is_last;
   logic                         is_hdr;
   udpc_pkg::action_type         act;

   udpc_pkg::action_type         action_ff;
   logic [udpc_pkg::TagW-1:0]    src_ff, dst_ff, seq_ff;
   logic                         cum_ff, last_ff;
   udpc_pkg::link_state_type     state_ff;

   assign load    = q_valid && (!valid_ff || rsp_pop);
   assign act     = q_head.acts[idx_ff];
   assign is_last = (udpc_pkg::RunCntW'(idx_ff) + udpc_pkg::RunCntW'(1)) == q_head.cnt;
   assign is_hdr  = (act == udpc_pkg::A_HPN) || (act == udpc_pkg::A_SYN)
                    || (act == udpc_pkg::A_ACK) || (act == udpc_pkg::A_NUL)
                    || (act == udpc_pkg::A_RST);
   assign q_pop   = load && is_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = is_last ? '0 : idx_ff + udpc_pkg::RunIdxW'(1);
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         action_ff <= act;
         src_ff    <= is_hdr ? q_head.own_tag : '0;
         dst_ff    <= is_hdr ? q_head.peer_tag : '0;
         seq_ff    <= (act == udpc_pkg::A_HPN || act == udpc_pkg::A_SYN) ? q_head.own_tag : '0;
         cum_ff    <= (act == udpc_pkg::A_ACK || act == udpc_pkg::A_NUL);
         last_ff   <= is_last;
         state_ff  <= q_head.state;
      end
   end

   assign rsp_empty         = !valid_ff;
   assign rsp_action        = action_ff;
   assign rsp_tx_src_tag    = src_ff;
   assign rsp_tx_dst_tag    = dst_ff;
   assign rsp_tx_seq        = seq_ff;
   assign rsp_needs_cum_ack = cum_ff;
   assign rsp_conn_state    = state_ff;
   assign rsp_last          = last_ff;

endmodule

// ===== verif/udp_connection_handshake_fsm_tb.sv =====
// self-checking testbench for the reliable-udp connection state machine
// depends on udpc_pkg and udp_connection_handshake_fsm with its front, queue and back modules
// drives events on the push/full side and checks every action popped against its own predictor
`timescale 1ns / 1ps

module udp_connection_handshake_fsm_tb;
   import udpc_pkg::*;

   // timing and run control
   localparam int TW               = TimerWidthDefault;
   localparam int HalfPeriod       = 6;
   localparam int LatencySlack     = 8;
   localparam int HoldCycles       = 90;
   localparam int StallLimit       = 2000;
   localparam int SaturationTicks  = 16;
   localparam int MaxPrinted       = 40;
   localparam int SpareIndex       = NumRegs;

   // header flag masks, msb first in the same order as hdr_flags_type
   localparam logic [7:0] F_SYN  = 8'h80;
   localparam logic [7:0] F_RST  = 8'h40;
   localparam logic [7:0] F_NUL  = 8'h20;
   localparam logic [7:0] F_ACK  = 8'h10;
   localparam logic [7:0] F_EAK  = 8'h08;
   localparam logic [7:0] F_RLE  = 8'h04;
   localparam logic [7:0] F_ANZ  = 8'h02;
   localparam logic [7:0] F_BODY = 8'h01;

   typedef struct packed {
      logic syn;
      logic rst;
      logic nul;
      logic ack;
      logic eak;
      logic rle;
      logic ack_nz;
      logic body_nz;
   } hdr_flags_type;

   // one event transaction as offered on the req_ side
   typedef struct packed {
      opcode_type    op;
      logic [31:0]   self_tag;
      logic [31:0]   remote_tag;
      hdr_flags_type flags;
   } link_event_type;

   // one expected action transaction on the rsp_ side
   typedef struct packed {
      action_type     act;
      logic [31:0]    src;
      logic [31:0]    dst;
      logic [31:0]    seq;
      logic           cum;
      link_state_type st;
      logic           last;
   } link_action_type;

   // directed script row; typed rows carry their single action and state by hand
   typedef struct packed {
      opcode_type     op;
      logic [31:0]    self_tag;
      logic [31:0]    remote_tag;
      logic [7:0]     flags;
      logic           typed;
      action_type     want_act;
      link_state_type want_st;
   } stim_row_type;

   // script assumes limits hpn 0, syn 1, ack 0, open 5, keep 2, inactive 3, close-wait 1
   localparam int ScriptLen = 26;
   localparam stim_row_type HandshakeScript [ScriptLen] = '{
      '{OP_TICK,  32'h0,         32'h0,         8'h00,                1'b1, A_NONE, ST_INIT},
      '{OP_RECV,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00,                1'b1, A_NONE, ST_INIT},
      '{OP_RECV,  32'h0,         32'h0,         F_NUL,                1'b0, A_NONE, ST_INIT},
      '{OP_RECV,  32'h0,         32'h0,         F_EAK | F_RLE | F_BODY, 1'b0, A_NONE, ST_INIT},
      '{OP_OPEN,  32'hFFFF_FFFF, 32'h0,         8'h00,                1'b1, A_SYN,  ST_SYNS},
      '{OP_OPEN,  32'h0,         32'hFFFF_FFFF, 8'h00,                1'b1, A_NONE, ST_SYNS},
      '{OP_TICK,  32'h0,         32'h0,         8'h00,                1'b0, A_NONE, ST_INIT},
      '{OP_TICK,  32'h0,         32'h0,         8'h00,                1'b0, A_NONE, ST_INIT},
      '{OP_RECV,  32'hA5A5_5A5A, 32'h0,         F_SYN | F_RST | F_ACK, 1'b0, A_NONE, ST_INIT},
      '{OP_RECV,  32'h5A5A_A5A5, 32'hFFFF_FFFF, F_SYN,                1'b0, A_NONE, ST_INIT},
      '{OP_TICK,  32'h0,         32'h0,         8'h00,                1'b0, A_NONE, ST_INIT},
      '{OP_TICK,  32'h0,         32'h0,         8'h00,                1'b0, A_NONE, ST_INIT},
      '{OP_TICK,  32'h0,         32'h0,         8'h00,                1'b0, A_NONE, ST_INIT},
      '{OP_RECV,  32'h0,         32'h0,         F_NUL | F_ACK | F_EAK, 1'b0, A_NONE, ST_INIT},
      '{OP_TICK,  32'h0,         32'h0,         8'h00,                1'b0, A_NONE, ST_INIT},
      '{OP_RECV,  32'h0,         32'h0,         F_ACK | F_ANZ,        1'b0, A_NONE, ST_INIT},
      '{OP_RECV,  32'h0,         32'h0,         F_BODY | F_RLE,       1'b0, A_NONE, ST_INIT},
      '{OP_RECV,  32'hFFFF_FFFF, 32'h0,         F_BODY,               1'b0, A_NONE, ST_INIT},
      '{OP_TICK,  32'h0,         32'h0,         8'h00,                1'b0, A_NONE, ST_INIT},
      '{OP_TICK,  32'h0,         32'h0,         8'h00,                1'b0, A_NONE, ST_INIT},
      '{OP_TICK,  32'h0,         32'h0,         8'h00,                1'b0, A_NONE, ST_INIT},
      '{OP_TICK,  32'h0,         32'h0,         8'h00,                1'b0, A_NONE, ST_INIT},
      '{OP_TICK,  32'h0,         32'h0,         8'h00,                1'b0, A_NONE, ST_INIT},
      '{OP_TICK,  32'h0,         32'h0,         8'h00,                1'b0, A_NONE, ST_INIT},
      '{OP_RECV,  32'h0,         32'h0,         F_RST,                1'b0, A_NONE, ST_INIT},
      '{OP_CLOSE, 32'h1234_5678, 32'h8765_4321, 8'h00,                1'b1, A_RST,  ST_CWAIT}
   };

   // clock, reset and every block input start at known values
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  csr_we    = 1'b0;
   logic [CsrIndexW-1:0]  csr_index = '0;
   logic [CsrDataW-1:0]   csr_wdata = '0;

   logic        push             = 1'b0;
   logic        full;
   logic [1:0]  req_opcode       = '0;
   logic [31:0] req_self_tag     = '0;
   logic [31:0] req_remote_tag   = '0;
   logic        req_flag_syn     = 1'b0;
   logic        req_flag_rst     = 1'b0;
   logic        req_flag_nul     = 1'b0;
   logic        req_flag_ack     = 1'b0;
   logic        req_flag_eak     = 1'b0;
   logic        req_flag_rle     = 1'b0;
   logic        req_ack_nonzero  = 1'b0;
   logic        req_body_nonzero = 1'b0;

   logic        empty;
   logic        pop = 1'b0;
   logic [3:0]  rsp_action;
   logic [31:0] rsp_tx_src_tag;
   logic [31:0] rsp_tx_dst_tag;
   logic [31:0] rsp_tx_seq;
   logic        rsp_needs_cum_ack;
   logic [2:0]  rsp_conn_state;
   logic        rsp_last;

   // predictor state: link, tags, tick timers and their limits
   link_state_type       link_now;
   logic [31:0]          link_own;
   logic [31:0]          link_peer;
   logic [TW-1:0]        tick_count [NumRegs];
   logic [CsrDataW-1:0]  tick_limit [NumRegs];
   action_type           run_acts [$];

   // actions predicted but not yet popped, oldest first
   link_action_type pending_actions [$];

   // stimulus pacing shared by the two sides
   bit rush         = 1'b0;
   bit hold_request = 1'b0;
   bit send_calm    = 1'b0;
   bit sink_calm    = 1'b0;

   int mismatch_count   = 0;
   int events_sent      = 0;
   int actions_checked  = 0;
   int settings_loaded  = 0;
   int stall_cycles     = 0;

   logic [CsrDataW-1:0] limits [NumRegs];

   udp_connection_handshake_fsm DUT (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .push              (push),
      .full              (full),
      .req_opcode        (req_opcode),
      .req_self_tag      (req_self_tag),
      .req_remote_tag    (req_remote_tag),
      .req_flag_syn      (req_flag_syn),
      .req_flag_rst      (req_flag_rst),
      .req_flag_nul      (req_flag_nul),
      .req_flag_ack      (req_flag_ack),
      .req_flag_eak      (req_flag_eak),
      .req_flag_rle      (req_flag_rle),
      .req_ack_nonzero   (req_ack_nonzero),
      .req_body_nonzero  (req_body_nonzero),
      .empty             (empty),
      .pop               (pop),
      .rsp_action        (rsp_action),
      .rsp_tx_src_tag    (rsp_tx_src_tag),
      .rsp_tx_dst_tag    (rsp_tx_dst_tag),
      .rsp_tx_seq        (rsp_tx_seq),
      .rsp_needs_cum_ack (rsp_needs_cum_ack),
      .rsp_conn_state    (rsp_conn_state),
      .rsp_last          (rsp_last)
   );

   // 12 ns clock
   always begin
      #HalfPeriod clock = 1'b1;
      #HalfPeriod clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   // the block caps a run at four actions
   function automatic void add_action(input action_type a);
      if (run_acts.size() < MaxRun) run_acts.push_back(a);
   endfunction

   // a timer fires once its count passes the limit; a saturated timer never passes all ones
   function automatic bit timer_due(input int idx);
      return tick_count[idx] > tick_limit[idx];
   endfunction

   // applies one event to the predicted link and leaves its action list in run_acts
   function automatic void advance_link(input link_event_type ev);
      int i;
      run_acts.delete();
      case (ev.op)
         OP_TICK: begin
            for (i = 0; i < NumRegs; i++)
               if (tick_count[i] != '1) tick_count[i] = tick_count[i] + 1'b1;
            if (link_now == ST_SYNS || link_now == ST_SYNR) begin
               // handshake resends and the open timeout, in this order
               if (timer_due(RegHpn)) begin
                  add_action(A_HPN);
                  tick_count[RegHpn] = '0;
               end
               if (timer_due(RegSyn)) begin
                  add_action(A_SYN);
                  tick_count[RegSyn] = '0;
               end
               if (link_now == ST_SYNR && timer_due(RegAck)) begin
                  add_action(A_ACK);
                  tick_count[RegAck] = '0;
               end
               if (timer_due(RegOpen)) begin
                  add_action(A_TMO);
                  tick_count[RegOpen] = '0;
               end
            end else begin
               if (link_now == ST_OPEN) begin
                  // reliable layer runs every tick, then keep-alive and inactivity
                  add_action(A_RRUN);
                  if (timer_due(RegKeep)) begin
                     add_action(A_NUL);
                     tick_count[RegKeep] = '0;
                  end
                  if (timer_due(RegInact)) begin
                     add_action(A_RST);
                     link_now = ST_CWAIT;
                     tick_count[RegCwait] = '0;
                  end
               end
               if (link_now == ST_CWAIT && timer_due(RegCwait)) begin
                  tick_count[RegCwait] = '0;
                  link_now = ST_CLOSED;
                  add_action(A_CLOSED);
               end
            end
         end
         OP_OPEN: begin
            // only the first open from initial counts
            if (link_now == ST_INIT) begin
               link_own  = ev.self_tag;
               link_peer = ev.remote_tag;
               add_action(A_SYN);
               link_now = ST_SYNS;
               tick_count[RegHpn]  = '0;
               tick_count[RegSyn]  = '0;
               tick_count[RegOpen] = '0;
            end
         end
         OP_CLOSE: begin
            // close-wait timer keeps counting from where it was
            add_action(A_RST);
            link_now = ST_CWAIT;
         end
         default: begin
            tick_count[RegKeep]  = '0;
            tick_count[RegInact] = '0;
            if (ev.flags.syn) begin
               // syn wins over every other flag
               link_own = ev.self_tag;
               case (link_now)
                  ST_CLOSED: begin
                     link_now = ST_SYNR;
                     add_action(A_SYN);
                  end
                  ST_SYNS: link_now = ST_SYNR;
                  ST_SYNR: begin
                     add_action(A_SYN);
                     add_action(A_ACK);
                  end
                  default: ;
               endcase
            end else if (ev.flags.rst) begin
               if (link_now != ST_CWAIT) begin
                  link_now = ST_CWAIT;
                  tick_count[RegCwait] = '0;
               end
            end else begin
               if (ev.flags.nul) add_action(A_ACK);
               if (ev.flags.ack) begin
                  if (link_now == ST_OPEN && ev.flags.ack_nz) begin
                     add_action(A_RACK);
                  end else if (link_now inside {ST_INIT, ST_SYNS, ST_SYNR}) begin
                     add_action(A_ACK);
                     link_now = ST_OPEN;
                     add_action(A_OPENED);
                  end
               end
               if (link_now == ST_OPEN) begin
                  if (ev.flags.eak) add_action(A_REAK);
                  else if (ev.flags.body_nz) add_action(ev.flags.rle ? A_RDATA : A_UDATA);
               end
            end
         end
      endcase
      if (run_acts.size() == 0) add_action(A_NONE);
   endfunction

   // turns run_acts into result transactions; tags go only on sent headers
   function automatic void queue_actions(input link_state_type st);
      link_action_type rec;
      bit              hdr;
      int              k;
      for (k = 0; k < run_acts.size(); k++) begin
         hdr      = (run_acts[k] >= A_HPN && run_acts[k] <= A_RST);
         rec.act  = run_acts[k];
         rec.src  = hdr ? link_own : '0;
         rec.dst  = hdr ? link_peer : '0;
         rec.seq  = (rec.act == A_HPN || rec.act == A_SYN) ? link_own : '0;
         rec.cum  = (rec.act == A_ACK || rec.act == A_NUL);
         rec.st   = st;
         rec.last = (k == run_acts.size() - 1);
         pending_actions.push_back(rec);
      end
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic int draw_gap(input bit calm);
      if (rush || calm) return 0;
      return $urandom_range(0, 18);
   endfunction

   // mostly events that move the link forward from where it is, plus noise
   function automatic link_event_type draw_event();
      link_event_type ev;
      int             pick;
      ev            = '0;
      ev.self_tag   = $urandom();
      ev.remote_tag = $urandom();
      pick          = $urandom_range(0, 99);
      if (pick < 40) ev.op = OP_TICK;
      else if (pick < 43) ev.op = OP_OPEN;
      else if (pick < 47) ev.op = OP_CLOSE;
      else begin
         ev.op = OP_RECV;
         if (pick < 57) begin
            ev.flags = 8'($urandom());
         end else begin
            case (link_now)
               ST_CLOSED: ev.flags.syn = 1'b1;
               ST_SYNR: begin
                  if ($urandom_range(0, 3) == 0) ev.flags.syn = 1'b1;
                  else begin
                     ev.flags.ack = 1'b1;
                     ev.flags.nul = 1'($urandom_range(0, 1));
                  end
               end
               ST_OPEN: begin
                  case ($urandom_range(0, 9))
                     0, 1, 2, 3: begin
                        ev.flags.body_nz = 1'b1;
                        ev.flags.rle     = 1'($urandom_range(0, 1));
                        ev.flags.ack     = 1'($urandom_range(0, 1));
                        ev.flags.ack_nz  = 1'($urandom_range(0, 1));
                     end
                     4, 5: begin
                        ev.flags.ack    = 1'b1;
                        ev.flags.ack_nz = 1'b1;
                     end
                     6: ev.flags.eak = 1'b1;
                     7: ev.flags.nul = 1'b1;
                     8: ev.flags.ack = 1'b1;
                     default: ev.flags.rst = 1'b1;
                  endcase
               end
               default: ev.flags = 8'($urandom());
            endcase
         end
      end
      return ev;
   endfunction

   // offers one event; push stays high into the next call when there is no gap
   task automatic issue_event(input link_event_type ev, input bit typed,
                              input action_type want_act, input link_state_type want_st);
      int gap;
      gap = hold_request ? 0 : draw_gap(send_calm);
      @(negedge clock);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_opcode       <= ev.op;
      req_self_tag     <= ev.self_tag;
      req_remote_tag   <= ev.remote_tag;
      {req_flag_syn, req_flag_rst, req_flag_nul, req_flag_ack, req_flag_eak,
       req_flag_rle, req_ack_nonzero, req_body_nonzero} <= ev.flags;
      push <= 1'b1;
      do @(posedge clock); while (full !== 1'b0);
      // accepted at this edge
      advance_link(ev);
      if (typed) begin
         run_acts.delete();
         run_acts.push_back(want_act);
         queue_actions(want_st);
      end else begin
         queue_actions(link_now);
      end
      events_sent++;
      if (events_sent % 32 == 0) send_calm = ($urandom_range(0, 2) == 0);
   endtask

   // stop offering, wait for every pending action, then let the pipeline settle
   task automatic drain();
      @(negedge clock);
      push <= 1'b0;
      while (pending_actions.size() != 0) @(posedge clock);
      repeat (LatencySlack) @(posedge clock);
   endtask

   // writes all seven limits while idle, optionally the unused index too
   task automatic load_limits(input bit poke_spare);
      int i;
      drain();
      for (i = 0; i < NumRegs; i++) begin
         @(negedge clock);
         csr_we    <= 1'b1;
         csr_index <= CsrIndexW'(i);
         csr_wdata <= limits[i];
         @(posedge clock);
         tick_limit[i] = limits[i];
      end
      if (poke_spare) begin
         // index past the list must leave every limit alone
         @(negedge clock);
         csr_index <= CsrIndexW'(SpareIndex);
         csr_wdata <= '1;
         @(posedge clock);
      end
      @(negedge clock);
      csr_we <= 1'b0;
      settings_loaded++;
   endtask

   task automatic random_batch(input int count, input int hold_at);
      int             n;
      link_event_type ev;
      for (n = 0; n < count; n++) begin
         ev = draw_event();
         // receiver backs off for a long stretch while events keep coming
         if (n == hold_at) hold_request = 1'b1;
         issue_event(ev, 1'b0, A_NONE, ST_INIT);
      end
   endtask

   task automatic report_mismatch(input string field, input logic [31:0] seen,
                                  input logic [31:0] want);
      if (mismatch_count < MaxPrinted)
         $display("mismatch at %0t: %s got %0h expected %0h", $realtime, field, seen, want);
      mismatch_count++;
   endtask

   // ---------------------------------------------------------------- result side

   initial begin : result_sink
      link_action_type want;
      int              gap;
      int              popped;
      popped = 0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         @(negedge clock);
         if (hold_request) begin
            pop <= 1'b0;
            repeat (HoldCycles) @(negedge clock);
            hold_request = 1'b0;
         end else begin
            gap = draw_gap(sink_calm);
            if (gap > 0) begin
               pop <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty !== 1'b0);
         // one action transaction taken at this edge
         if (pending_actions.size() == 0) begin
            report_mismatch("unexpected action", rsp_action, '0);
         end else begin
            want = pending_actions.pop_front();
            if (rsp_action !== want.act)         report_mismatch("action", rsp_action, want.act);
            if (rsp_tx_src_tag !== want.src)     report_mismatch("src tag", rsp_tx_src_tag, want.src);
            if (rsp_tx_dst_tag !== want.dst)     report_mismatch("dst tag", rsp_tx_dst_tag, want.dst);
            if (rsp_tx_seq !== want.seq)         report_mismatch("seq", rsp_tx_seq, want.seq);
            if (rsp_needs_cum_ack !== want.cum)  report_mismatch("cum ack", rsp_needs_cum_ack, want.cum);
            if (rsp_conn_state !== want.st)      report_mismatch("state", rsp_conn_state, want.st);
            if (rsp_last !== want.last)          report_mismatch("last", rsp_last, want.last);
            actions_checked++;
         end
         popped++;
         if (popped % 32 == 0) sink_calm = ($urandom_range(0, 2) == 0);
      end
   end

   // watchdog: a stretch with no transaction on any port that reaches the stall limit ends the run
   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty) || csr_we) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
         $display("watchdog: no transaction for %0d cycles, %0d actions still due",
                  stall_cycles, pending_actions.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------- main sequence

   initial begin : main_flow
      int             r;
      int             i;
      link_event_type ev;

      // predictor starts from the reset state
      link_now  = ST_INIT;
      link_own  = '0;
      link_peer = '0;
      for (i = 0; i < NumRegs; i++) begin
         tick_count[i] = '0;
         tick_limit[i] = RegReset[i];
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // short limits so the handshake script sees every timer but the open timeout fire
      limits[RegHpn]   = 16'd0;
      limits[RegSyn]   = 16'd1;
      limits[RegAck]   = 16'd0;
      limits[RegOpen]  = 16'd5;
      limits[RegKeep]  = 16'd2;
      limits[RegInact] = 16'd3;
      limits[RegCwait] = 16'd1;
      load_limits(1'b1);

      // directed handshake: initial, open, syn exchange, open link, timeouts, close
      for (r = 0; r < ScriptLen; r++) begin
         ev.op         = HandshakeScript[r].op;
         ev.self_tag   = HandshakeScript[r].self_tag;
         ev.remote_tag = HandshakeScript[r].remote_tag;
         ev.flags      = HandshakeScript[r].flags;
         issue_event(ev, HandshakeScript[r].typed, HandshakeScript[r].want_act,
                     HandshakeScript[r].want_st);
      end

      // small random limits, with one long receiver hold-off
      for (i = 0; i < NumRegs; i++) limits[i] = 16'($urandom_range(0, 6));
      load_limits(1'b0);
      random_batch(120, 30);

      // back to the power-on limits
      for (i = 0; i < NumRegs; i++) limits[i] = RegReset[i];
      load_limits(1'b0);
      random_batch(40, -1);

      // every timer fires on its first tick
      for (i = 0; i < NumRegs; i++) limits[i] = '0;
      load_limits(1'b0);
      random_batch(60, -1);

      // all-ones limits: nothing fires; then a zero close-wait limit closes on the next tick
      rush = 1'b1;
      for (i = 0; i < NumRegs; i++) limits[i] = '1;
      load_limits(1'b1);
      ev = '0;
      ev.op = OP_CLOSE;
      issue_event(ev, 1'b0, A_NONE, ST_INIT);
      ev.op = OP_TICK;
      for (i = 0; i < SaturationTicks; i++) issue_event(ev, 1'b0, A_NONE, ST_INIT);
      limits[RegCwait] = '0;
      load_limits(1'b0);
      issue_event(ev, 1'b0, A_NONE, ST_INIT);
      rush = 1'b0;

      // mixed tiny and full-range limits
      for (i = 0; i < NumRegs; i++)
         limits[i] = $urandom_range(0, 1) ? 16'($urandom_range(0, 4)) : 16'($urandom());
      load_limits(1'b0);
      random_batch(60, -1);

      // very short limits, second hold-off
      for (i = 0; i < NumRegs; i++) limits[i] = 16'($urandom_range(0, 3));
      load_limits(1'b0);
      random_batch(100, 50);

      drain();

      $display("run covered %0d events and %0d checked actions over %0d limit settings",
               events_sent, actions_checked, settings_loaded);
      $display("including the scripted handshake, two receiver hold-offs and a %0d-tick %s",
               SaturationTicks, "stretch at all-ones limits");
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
